// ===== design/pjq_pkg.sv =====
// shared types and constants for the per-object priority job queue
`default_nettype none

package pjq_pkg;

    localparam int ID_W       = 32;
    localparam int PRIO_W     = 8;
    localparam int LIMIT_W    = 4;
    localparam int LIMIT_REGS = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    // request kinds; the fourth code means nothing
    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_CANCEL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PUSH_RD,
        S_PUSH_CHK,
        S_PUSH_PUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REMOVE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/per_object_priority_job_queue.sv =====
// top level: per-object sorted job queues walked by a small sequencer
//
//   channel   signals                                        direction
//   -------   --------------------------------------------   ---------
//   in        in_valid/in_ready, kind, object, job_id,       request in
//             priority_req
//   out       out_valid/out_ready, status, head_job_id,      result out
//             head_priority, fill_count, object_idle
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data       limit write
//
// per request: one read, then a compare or a move, for each entry visited;
//   the next request is accepted only once the result has been loaded
// reset: fills clear and limits go to 8; entries are never cleared
// stalls: the sequencer holds in its finish state while the last result waits
// cfg is always ready; the user writes it only while no request is in flight, the block does not enforce this

`default_nettype none

module per_object_priority_job_queue
    import pjq_pkg::*;
#(
    parameter int NUM_OBJECTS = 4,
    parameter int QUEUE_DEPTH = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           kind,
    input  wire logic [1:0]           object,
    input  wire logic [ID_W-1:0]      job_id,
    input  wire logic [PRIO_W-1:0]    priority_req,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [ID_W-1:0]           head_job_id,
    output logic [PRIO_W-1:0]         head_priority,
    output logic [3:0]                fill_count,
    output logic                      object_idle,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_data
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OBJ_W  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int SLOTS  = NUM_OBJECTS * QUEUE_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

    localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(QUEUE_DEPTH);
    localparam logic [FILL_W:0]   DEPTH_EXT = (FILL_W + 1)'(QUEUE_DEPTH);

    // sequencer state
    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    status_t             res_status_reg, res_status_next;
    entry_t              res_head_reg, res_head_next;
    logic                res_idle_reg, res_idle_next;

    // latched request
    logic [1:0]          op_reg;
    logic [1:0]          obj_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PRIO_W-1:0]   prio_reg;

    // per-object fill counts and limits
    logic [FILL_W-1:0]   fill_reg [NUM_OBJECTS];
    logic [LIMIT_W-1:0]  limit_reg [LIMIT_REGS];
    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata;

    // output register
    logic                out_valid_reg;
    status_t             out_status_reg;
    entry_t              out_head_reg;
    logic [3:0]          out_fill_reg;
    logic                out_idle_reg;
    logic                out_load;

    // entry memory port
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t              rd_data;

    logic                obj_ok;
    logic [OBJ_W-1:0]    obj_idx;
    logic [FILL_W-1:0]   fill_cur;
    logic [FILL_W:0]     fill_ext;
    logic [FILL_W:0]     idx_inc;
    logic [FILL_W:0]     idx_inc2;
    logic [CMP_W-1:0]    lim_raw;
    logic [CMP_W-1:0]    eff_lim;
    logic                push_busy;
    logic [ADDR_W-1:0]   obj_base;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // request decode
    assign obj_ok   = (int'(obj_reg) < NUM_OBJECTS);
    assign obj_idx  = OBJ_W'(obj_reg);
    assign fill_cur = fill_reg[obj_idx];
    assign fill_ext = {1'b0, fill_cur};
    assign idx_inc  = {1'b0, idx_reg} + (FILL_W + 1)'(1);
    assign idx_inc2 = {1'b0, idx_reg} + (FILL_W + 1)'(2);

    // limit zero acts as one, anything past the depth saturates
    assign lim_raw = CMP_W'(limit_reg[obj_reg]);
    always_comb
    begin
        if (lim_raw == '0)
        begin
            eff_lim = CMP_W'(1);
        end
        else if (lim_raw > DEPTH_CMP)
        begin
            eff_lim = DEPTH_CMP;
        end
        else
        begin
            eff_lim = lim_raw;
        end
    end

    // an empty queue always takes the job
    assign push_busy = (fill_cur != '0) && (CMP_W'(fill_cur) >= eff_lim);

    // each object owns a contiguous slice of the entry memory
    assign obj_base = ADDR_W'(int'(obj_idx) * QUEUE_DEPTH);
    assign wr_addr  = obj_base + ADDR_W'(idx_reg);

    always_comb
    begin
        case (state_reg)
            S_PUSH_RD:  rd_addr = obj_base + ADDR_W'(idx_reg - FILL_W'(1));
            S_SHIFT_RD: rd_addr = obj_base + ADDR_W'(idx_inc);
            default:    rd_addr = obj_base + ADDR_W'(idx_reg);
        endcase
    end

    pjq_store #(
        .SLOTS  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        res_idle_next   = res_idle_reg;
        fill_we         = 1'b0;
        fill_wdata      = fill_cur;
        wr_en           = 1'b0;
        wr_data         = rd_data;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_status_next = ST_FAIL;
                res_head_next   = '0;
                res_idle_next   = 1'b0;
                idx_next        = '0;
                state_next      = S_FINISH;
                if (obj_ok)
                begin
                    case (op_reg)
                        KIND_PUSH:
                        begin
                            if (push_busy)
                            begin
                                res_status_next = ST_BUSY;
                            end
                            else
                            begin
                                // walk back from the tail
                                idx_next   = fill_cur;
                                state_next = (fill_cur == '0) ? S_PUSH_PUT : S_PUSH_RD;
                            end
                        end
                        KIND_POP, KIND_CANCEL:
                        begin
                            if (fill_cur != '0)
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_PUSH_RD:
            begin
                state_next = S_PUSH_CHK;
            end

            S_PUSH_CHK:
            begin
                // stop behind the last entry of equal or higher priority
                if (rd_data.prio >= prio_reg)
                begin
                    state_next = S_PUSH_PUT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    idx_next   = idx_reg - FILL_W'(1);
                    state_next = (idx_reg == FILL_W'(1)) ? S_PUSH_PUT : S_PUSH_RD;
                end
            end

            S_PUSH_PUT:
            begin
                wr_en           = 1'b1;
                wr_data.id      = id_reg;
                wr_data.prio    = prio_reg;
                fill_we         = 1'b1;
                fill_wdata      = fill_cur + FILL_W'(1);
                res_status_next = ST_OK;
                state_next      = S_FINISH;
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                // pop takes the head unconditionally
                if ((op_reg == KIND_POP) || (rd_data.id == id_reg))
                begin
                    if (op_reg == KIND_POP)
                    begin
                        res_head_next = rd_data;
                    end
                    state_next = (idx_inc < fill_ext) ? S_SHIFT_RD : S_REMOVE;
                end
                else
                begin
                    idx_next   = FILL_W'(idx_inc);
                    state_next = (idx_inc < fill_ext) ? S_SCAN_RD : S_FINISH;
                end
            end

            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                // close the gap one entry at a time
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = FILL_W'(idx_inc);
                state_next = (idx_inc2 < fill_ext) ? S_SHIFT_RD : S_REMOVE;
            end

            S_REMOVE:
            begin
                fill_we         = 1'b1;
                fill_wdata      = fill_cur - FILL_W'(1);
                res_status_next = ST_OK;
                res_idle_next   = (op_reg == KIND_CANCEL) && (fill_cur == FILL_W'(1));
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            res_status_reg <= ST_FAIL;
            res_head_reg   <= '0;
            res_idle_reg   <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            res_status_reg <= res_status_next;
            res_head_reg   <= res_head_next;
            res_idle_reg   <= res_idle_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= kind;
            obj_reg  <= object;
            id_reg   <= job_id;
            prio_reg <= priority_req;
        end
    end

    // fill counts and limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OBJECTS; i++)
            begin
                fill_reg[i] <= '0;
            end
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                limit_reg[i] <= LIMIT_RESET;
            end
        end
        else
        begin
            if (fill_we)
            begin
                fill_reg[obj_idx] <= fill_wdata;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_head_reg   <= res_head_reg;
            out_fill_reg   <= obj_ok ? 4'(fill_cur) : 4'd0;
            out_idle_reg   <= res_idle_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign head_job_id   = out_head_reg.id;
    assign head_priority = out_head_reg.prio;
    assign fill_count    = out_fill_reg;
    assign object_idle   = out_idle_reg;

    // an accepted request always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_START)
        else $error("accepted request did not start the sequencer");

    // memory writes stay inside the addressed object's slice
    a_write_in_slice: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> obj_ok && (int'(idx_reg) < QUEUE_DEPTH))
        else $error("entry write outside the object's slice");

    // a valid object's fill count never passes the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        obj_ok |-> fill_ext <= DEPTH_EXT)
        else $error("fill count beyond queue depth");

    // busy is only ever reported for a push
    a_busy_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (res_status_reg == ST_BUSY) |-> op_reg == KIND_PUSH)
        else $error("busy status on a non-push request");

endmodule

`default_nettype wire

// ===== design/pjq_store.sv =====
// job entry memory: one write port, one registered read port
`default_nettype none

module pjq_store
    import pjq_pkg::*;
#(
    parameter int SLOTS  = 32,
    parameter int ADDR_W = 5
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== verif/per_object_priority_job_queue_tb.sv =====
// testbench for the per-object priority job queue: directed and random requests, self-checking
module per_object_priority_job_queue_tb;
    import pjq_pkg::*;

    localparam int NUM_OBJECTS = 4;
    localparam int QUEUE_DEPTH = 8;

    // the fourth kind code has no meaning in the block and must answer a failure
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // no request moving on any channel for this long means the block is stuck
    localparam int IDLE_LIMIT  = 2000;
    // long enough for one request to walk its whole queue
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        obj;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } job_req_t;

    // same field order as the result ports, so the ports can be packed straight in
    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   head_id;
        logic [PRIO_W-1:0] head_prio;
        logic [3:0]        fill;
        logic              idle;
    } job_answer_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [1:0]           kind         = KIND_PUSH;
    logic [1:0]           object       = '0;
    logic [ID_W-1:0]      job_id       = '0;
    logic [PRIO_W-1:0]    priority_req = '0;

    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [1:0]           status;
    logic [ID_W-1:0]      head_job_id;
    logic [PRIO_W-1:0]    head_priority;
    logic [3:0]           fill_count;
    logic                 object_idle;

    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [LIMIT_W-1:0]   cfg_data     = '0;

    per_object_priority_job_queue #(
        .NUM_OBJECTS (NUM_OBJECTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .object        (object),
        .job_id        (job_id),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .head_job_id   (head_job_id),
        .head_priority (head_priority),
        .fill_count    (fill_count),
        .object_idle   (object_idle),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow of the job queues, limits and bookkeeping
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    job_ids      [NUM_OBJECTS][QUEUE_DEPTH];
    logic [PRIO_W-1:0]  job_prios    [NUM_OBJECTS][QUEUE_DEPTH];
    int unsigned        job_count    [NUM_OBJECTS];
    logic [LIMIT_W-1:0] limit_shadow [LIMIT_REGS];

    job_req_t    pending_reqs[$];     // requests not yet offered to the block
    job_answer_t awaited_answers[$];  // predicted results, oldest first

    int errors       = 0;
    int reqs_taken   = 0;
    int answers_seen = 0;
    int busy_seen    = 0;
    int fail_seen    = 0;
    int idle_seen    = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;

    // sender burst state and receiver stall pattern
    int          burst_left    = 0;
    int          gap_left      = 0;
    logic [15:0] ready_pattern = '1;
    int          pattern_hold  = 0;

    // close the hole at pos by pulling the tail forward one slot
    function automatic void drop_entry(int obj, int pos);
        for (int i = pos; i + 1 < job_count[obj]; i++)
        begin
            job_ids[obj][i]   = job_ids[obj][i + 1];
            job_prios[obj][i] = job_prios[obj][i + 1];
        end
        job_count[obj]--;
    endfunction

    // apply one request to the shadow queues and return the result it must produce
    function automatic job_answer_t apply_job_request(job_req_t r);
        job_answer_t a;
        int          n;
        int          pos;
        int          lim;
        bit          found;
        a        = '0;
        a.status = ST_FAIL;
        n        = job_count[r.obj];
        found    = 1'b0;
        case (r.kind)
            KIND_PUSH:
            begin
                // limit zero behaves as one, anything past the depth saturates
                lim = int'(limit_shadow[r.obj]);
                if (lim == 0)
                    lim = 1;
                if (lim > QUEUE_DEPTH)
                    lim = QUEUE_DEPTH;
                // an empty queue always takes the job
                if ((n != 0 && n >= lim) || n >= QUEUE_DEPTH)
                    a.status = ST_BUSY;
                else
                begin
                    // go behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < n && job_prios[r.obj][pos] >= r.prio)
                        pos++;
                    for (int i = n; i > pos; i--)
                    begin
                        job_ids[r.obj][i]   = job_ids[r.obj][i - 1];
                        job_prios[r.obj][i] = job_prios[r.obj][i - 1];
                    end
                    job_ids[r.obj][pos]   = r.id;
                    job_prios[r.obj][pos] = r.prio;
                    job_count[r.obj]      = n + 1;
                    a.status              = ST_OK;
                end
            end
            KIND_POP:
            begin
                if (n > 0)
                begin
                    a.head_id   = job_ids[r.obj][0];
                    a.head_prio = job_prios[r.obj][0];
                    drop_entry(r.obj, 0);
                    a.status    = ST_OK;
                end
            end
            KIND_CANCEL:
            begin
                // first matching id only, duplicates further back stay
                for (int i = 0; i < n; i++)
                begin
                    if (!found && job_ids[r.obj][i] == r.id)
                    begin
                        found = 1'b1;
                        drop_entry(r.obj, i);
                        a.status = ST_OK;
                        a.idle   = (job_count[r.obj] == 0);
                    end
                end
            end
            default:
            begin
                // unused kind: nothing changes
            end
        endcase
        a.fill = 4'(job_count[r.obj]);
        return a;
    endfunction

    task automatic report_mismatch(string what, job_answer_t got, job_answer_t want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t %s: got %0d/%h/%0d/%0d/%0b want %0d/%h/%0d/%0d/%0b",
                     $time, what,
                     got.status, got.head_id, got.head_prio, got.fill, got.idle,
                     want.status, want.head_id, want.head_prio, want.fill, want.idle);
    endtask

    // ------------------------------------------------------------------
    // driver: offers pending requests in bursts with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        job_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            // the previous request (if any) was taken at this edge
            if (gap_left > 0 || pending_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                nxt = pending_reqs.pop_front();
                in_valid     <= 1'b1;
                kind         <= nxt.kind;
                object       <= nxt.obj;
                job_id       <= nxt.id;
                priority_req <= nxt.prio;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // a quarter of bursts run back to back with no gap at all
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every taken request, checks every taken result,
    // and drives the receiver's stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        job_answer_t got;
        job_answer_t want;
        int          pick;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                awaited_answers.push_back(
                    apply_job_request({kind, object, job_id, priority_req}));
                reqs_taken++;
            end
            if (out_valid && out_ready)
            begin
                got = {status, head_job_id, head_priority, fill_count, object_idle};
                if (awaited_answers.size() == 0)
                    report_mismatch("result with no request outstanding", got, '0);
                else
                begin
                    want = awaited_answers.pop_front();
                    answers_seen++;
                    if (want.status == ST_BUSY)
                        busy_seen++;
                    if (want.status == ST_FAIL)
                        fail_seen++;
                    if (want.idle)
                        idle_seen++;
                    if (got.status !== want.status || got.head_id !== want.head_id
                        || got.head_prio !== want.head_prio || got.fill !== want.fill
                        || got.idle !== want.idle)
                        report_mismatch("result mismatch", got, want);
                end
            end
        end

        // stall pattern: always ready, a random mask, or a sparse mask;
        // bit zero is forced so every mask holds at least one ready slot in its rotation
        if (pattern_hold == 0)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                ready_pattern = '1;
            else if (pick == 1)
                ready_pattern = 16'($urandom) | 16'd1;
            else
                ready_pattern = 16'($urandom & $urandom) | 16'd1;
            pattern_hold = $urandom_range(40, 120);
        end
        else
        begin
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_hold--;
        end
        out_ready <= rst_n && ready_pattern[0];
    end

    // ------------------------------------------------------------------
    // watchdog: nothing moving on any channel for too long ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t no request moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, awaited_answers.size());
            $display("per_object_priority_job_queue_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(logic [1:0] k, int o, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
        job_req_t r;
        r.kind = k;
        r.obj  = 2'(o);
        r.id   = id;
        r.prio = pr;
        pending_reqs.push_back(r);
    endtask

    // small ids and a few fixed priorities make cancel hits and priority ties common
    task automatic add_random_reqs(int count, int push_pct, int pop_pct);
        int roll;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            queue_req((roll < 3) ? KIND_UNUSED :
                      (roll < 3 + push_pct) ? KIND_PUSH :
                      (roll < 3 + push_pct + pop_pct) ? KIND_POP : KIND_CANCEL,
                      $urandom_range(0, NUM_OBJECTS - 1),
                      ($urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                                  : ID_W'($urandom_range(0, 15)),
                      ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom)
                                                  : PRIO_W'($urandom_range(0, 3) * 85));
        end
    endtask

    // sender holds back until every predicted result has come, then a short pause
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || awaited_answers.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // limits only change with the block idle
    task automatic set_limits(logic [LIMIT_W-1:0] l0, logic [LIMIT_W-1:0] l1,
                              logic [LIMIT_W-1:0] l2, logic [LIMIT_W-1:0] l3);
        logic [LIMIT_W-1:0] vals [LIMIT_REGS];
        vals = '{l0, l1, l2, l3};
        wait_quiet();
        for (int i = 0; i < LIMIT_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            limit_shadow[i] = vals[i];
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : run_test
        for (int o = 0; o < NUM_OBJECTS; o++)
        begin
            job_count[o] = 0;
            for (int e = 0; e < QUEUE_DEPTH; e++)
            begin
                job_ids[o][e]   = '0;
                job_prios[o][e] = '0;
            end
        end
        for (int i = 0; i < LIMIT_REGS; i++)
            limit_shadow[i] = LIMIT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue cases and the unused kind
        queue_req(KIND_POP,    0, '0, '0);
        queue_req(KIND_CANCEL, 1, '0, '0);
        queue_req(KIND_UNUSED, 2, '1, '1);
        // fill object 0 to the depth: extremes, equal priorities keep arrival order
        queue_req(KIND_PUSH, 0, 32'h0000_0000, 8'd0);
        queue_req(KIND_PUSH, 0, 32'hFFFF_FFFF, 8'd255);
        queue_req(KIND_PUSH, 0, 32'd1, 8'd128);
        queue_req(KIND_PUSH, 0, 32'd2, 8'd128);
        queue_req(KIND_PUSH, 0, 32'd3, 8'd255);
        queue_req(KIND_PUSH, 0, 32'h8000_0000, 8'd1);
        queue_req(KIND_PUSH, 0, 32'd4, 8'd254);
        queue_req(KIND_PUSH, 0, 32'd5, 8'd128);
        // full queue refuses, unused kind reports the fill
        queue_req(KIND_PUSH,   0, 32'd6, 8'd200);
        queue_req(KIND_UNUSED, 0, 32'd6, 8'd200);
        // cancel from the middle, from the tail, and one with no match
        queue_req(KIND_CANCEL, 0, 32'd2, '0);
        queue_req(KIND_CANCEL, 0, 32'd0, '0);
        queue_req(KIND_CANCEL, 0, 32'd777, '0);
        // drain by pops, then one pop too many
        repeat (6) queue_req(KIND_POP, 0, '0, '0);
        queue_req(KIND_POP, 0, '0, '0);
        // cancel of the last job marks the object idle
        queue_req(KIND_PUSH,   3, 32'd9, 8'd7);
        queue_req(KIND_CANCEL, 3, 32'd9, '0);

        add_random_reqs(150, 50, 25);

        // one slot, full depth, zero acting as one, and saturation past the depth
        set_limits(4'd1, 4'd8, 4'd0, 4'd15);
        add_random_reqs(130, 45, 25);

        set_limits(4'd2, 4'd3, 4'd4, 4'd5);
        add_random_reqs(130, 55, 20);

        // random settings across the whole register range
        repeat (3)
        begin
            set_limits(LIMIT_W'($urandom), LIMIT_W'($urandom),
                       LIMIT_W'($urandom), LIMIT_W'($urandom));
            add_random_reqs(100, 40, 30);
        end

        wait_quiet();
        $display("covered %0d requests, %0d results checked: %0d busy, %0d empty or unmatched",
                 reqs_taken, answers_seen, busy_seen, fail_seen);
        $display("%0d cancels left an object idle, %0d limit register writes, %0d mismatches",
                 idle_seen, cfg_writes, errors);
        if (errors == 0)
            $display("per_object_priority_job_queue_tb: done, clean");
        else
            $display("per_object_priority_job_queue_tb: done, errors");
        $finish;
    end

endmodule
